// ----- src/fully_connected_layer_engine_macros.svh -----
// Assertion macros shared by the engine's modules.
`ifndef FULLY_CONNECTED_LAYER_ENGINE_MACROS_SVH
`define FULLY_CONNECTED_LAYER_ENGINE_MACROS_SVH

// Same-cycle implication on clk_i, muted while rst_ni is low.
`define FC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, muted while rst_ni is low.
`define FC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fc_pkg.sv -----
// Shared types and constants of the fully connected layer engine.
package fc_pkg;

  localparam int LANES = 16;

  localparam logic [1:0] FUNC_WLOAD = 2'd0;
  localparam logic [1:0] FUNC_BLOAD = 2'd1;
  localparam logic [1:0] FUNC_FWD   = 2'd2;
  localparam logic [1:0] FUNC_BWD   = 2'd3;

  localparam logic [1:0] REG_GRAD_MUTE = 2'd0;
  localparam logic [1:0] REG_IN_USED   = 2'd1;
  localparam logic [1:0] REG_OUT_USED  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WLOAD,
    OP_BLOAD,
    OP_FWD,
    OP_BWD
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT_RD,
    ST_EMIT_WR
  } st_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
    logic               active;
  } cmd_t;

  // Clamped counts and mode bit; the user must keep them stable while the block is busy, the block does not enforce it.
  typedef struct packed {
    logic       first;
    logic [4:0] ni;
    logic [4:0] no;
  } cfg_t;

endpackage

// ----- src/fc_front.sv -----
// Front end: decode an input beat into a command for the queue.
module fc_front import fc_pkg::*; #(
  parameter int MAX_IN  = 16,
  parameter int MAX_OUT = 16
) (
  input  logic [1:0]  func_i,
  input  logic [23:0] data_i,
  input  logic        last_i,
  input  cfg_t        cfg_i,
  output cmd_t        cmd_o
);

  logic [3:0] row, col;
  logic       in_rng_row, in_rng_col, act;

  assign row = data_i[3:0];
  assign col = data_i[7:4];
  assign in_rng_row = 7'(row) < 7'(MAX_IN);
  assign in_rng_col = 7'(col) < 7'(MAX_OUT);

  always_comb begin
    cmd_o.row    = row;
    cmd_o.col    = col;
    cmd_o.value  = signed'(data_i[23:8]);
    cmd_o.last   = last_i;
    cmd_o.active = 1'b0;
    cmd_o.op     = OP_NONE;
    act          = 1'b0;
    case (func_i)
      FUNC_WLOAD: begin
        if (in_rng_row && in_rng_col) cmd_o.op = OP_WLOAD;
      end
      FUNC_BLOAD: begin
        if (in_rng_col) cmd_o.op = OP_BLOAD;
      end
      FUNC_FWD: begin
        act = 5'(row) < cfg_i.ni;
        cmd_o.active = act;
        if (act || last_i) cmd_o.op = OP_FWD;
      end
      default: begin
        act = 5'(col) < cfg_i.no;
        cmd_o.active = act;
        if (act || last_i) cmd_o.op = OP_BWD;
      end
    endcase
  end

endmodule

// ----- src/fc_queue.sv -----
// Two-entry command queue between front and back.
module fc_queue import fc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- src/fc_back.sv -----
// Back end: weight and bias memories, shared MAC sequencer, result register.
module fc_back import fc_pkg::*; #(
  parameter int MAX_IN  = 16,
  parameter int MAX_OUT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  cmd_t        q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] out_data_o,
  output logic        out_last_o
);
  `include "fully_connected_layer_engine_macros.svh"

  localparam int WD = MAX_IN * MAX_OUT;
  localparam int AW = (WD > 1) ? $clog2(WD) : 1;
  localparam int BW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  st_e  state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [4:0] lane_q, lane_d, n_q, n_d;

  logic [15:0] wmem [WD];
  logic [15:0] bmem [MAX_OUT];
  logic [15:0] w_rdata_q, b_rdata_q;
  logic        w_we, b_we;
  logic [AW-1:0] w_waddr, w_raddr;

  logic        iss;
  logic        rd_v_q, prod_v_q;
  logic [3:0]  rd_lane_q, prod_lane_q;
  logic signed [31:0] prod_q;

  logic [39:0] acc_q [LANES];
  logic [LANES-1:0] acc_valid_q;
  logic [3:0]  acc_raddr;
  logic [39:0] acc_cur, acc_rd_q;
  logic        acc_clr, emit_rd;

  logic        out_valid_q, out_valid_d, out_last_q, out_load, last_res;
  logic [3:0]  out_index_q;
  logic [15:0] out_value_q, res;
  logic [39:0] sum;
  logic signed [27:0] shq;

  always_comb begin
    w_waddr = AW'(int'(q_data_i.row) * MAX_OUT + int'(q_data_i.col));
    if (cmd_q.op == OP_FWD) w_raddr = AW'(int'(cmd_q.row) * MAX_OUT + int'(lane_q[3:0]));
    else w_raddr = AW'(int'(lane_q[3:0]) * MAX_OUT + int'(cmd_q.col));
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_waddr] <= q_data_i.value;
    w_rdata_q <= wmem[w_raddr];
    if (b_we) bmem[BW'(q_data_i.col)] <= q_data_i.value;
    b_rdata_q <= bmem[BW'(lane_q)];
  end

  assign acc_raddr = (state_q == ST_MAC) ? prod_lane_q : lane_q[3:0];
  assign acc_cur   = acc_valid_q[acc_raddr] ? acc_q[acc_raddr] : 40'd0;

  // In forward mode the bias enters as b * 2^12; floor shift then saturate.
  always_comb begin
    sum = acc_rd_q;
    if (cmd_q.op == OP_FWD) sum = acc_rd_q + {{12{b_rdata_q[15]}}, b_rdata_q, 12'd0};
    shq = signed'(sum[39:12]);
    if (shq > 28'sd32767) res = 16'h7fff;
    else if (shq < -28'sd32768) res = 16'h8000;
    else res = shq[15:0];
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    lane_d  = lane_q;
    n_d     = n_q;
    q_pop_o = 1'b0;
    w_we    = 1'b0;
    b_we    = 1'b0;
    iss     = 1'b0;
    acc_clr = 1'b0;
    emit_rd = 1'b0;
    out_load = 1'b0;
    last_res = (lane_q + 5'd1) == n_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          lane_d  = 5'd0;
          case (q_data_i.op)
            OP_WLOAD: w_we = 1'b1;
            OP_BLOAD: b_we = 1'b1;
            OP_FWD, OP_BWD: begin
              if (!q_data_i.active) n_d = 5'd0;
              else n_d = (q_data_i.op == OP_FWD) ? cfg_i.no : cfg_i.ni;
              state_d = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        iss = lane_q < n_q;
        if (iss) lane_d = lane_q + 5'd1;
        if (!iss && !rd_v_q && !prod_v_q) begin
          lane_d = 5'd0;
          if (!cmd_q.last) begin
            state_d = ST_IDLE;
          end else if (cmd_q.op == OP_BWD && cfg_i.first) begin
            acc_clr = 1'b1;
            state_d = ST_IDLE;
          end else begin
            n_d = (cmd_q.op == OP_FWD) ? cfg_i.no : cfg_i.ni;
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        emit_rd = 1'b1;
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          lane_d   = lane_q + 5'd1;
          if (last_res) begin
            acc_clr = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i) begin
    rd_lane_q   <= lane_q[3:0];
    prod_lane_q <= rd_lane_q;
    if (rd_v_q) prod_q <= cmd_q.value * signed'(w_rdata_q);
    if (prod_v_q) acc_q[prod_lane_q] <= acc_cur + {{8{prod_q[31]}}, prod_q};
    if (emit_rd) acc_rd_q <= acc_cur;
    if (out_load) begin
      out_index_q <= lane_q[3:0];
      out_value_q <= res;
      out_last_q  <= last_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      lane_q      <= 5'd0;
      n_q         <= 5'd0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      acc_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      lane_q   <= lane_d;
      n_q      <= n_d;
      rd_v_q   <= iss;
      prod_v_q <= rd_v_q;
      if (acc_clr) acc_valid_q <= '0;
      else if (prod_v_q) acc_valid_q[prod_lane_q] <= 1'b1;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'd0, out_value_q, out_index_q};
  assign out_last_o  = out_last_q;

  `FC_ASSERT_IMPL(a_pop_idle, q_pop_o, state_q == ST_IDLE, "queue popped while busy")
  `FC_ASSERT_IMPL(a_load_free, out_load, !out_valid_q || out_ready_i, "result overwritten")
  `FC_ASSERT_NEXT(a_mac_pipe, rd_v_q, prod_v_q && state_q == ST_MAC, "MAC pipeline broken")

endmodule

// ----- src/fully_connected_layer_engine.sv -----
// Top level of the fully connected layer engine.
//
// Input stream s_axis: tuser carries func (load weight, load bias, forward
// element, backward gradient element), tdata carries row_index, col_index
// and value, tlast marks the final element of a row. Output stream m_axis
// carries out_index and out_value in tdata; tlast marks the final result.
// Configuration: write the gradient mute bit, in_used, out_used through
// cfg_we_i, cfg_index_i and cfg_data_i only while the engine is idle.
// Beats land in a two-entry command queue; the back end pops one at a time.
// A load is written straight from the idle state. An element in use is
// walked over n lanes, n being the lane count (out_used forward, in_used
// backward), by the single shared multiplier, one lane per cycle through
// the two-stage read and multiply pipeline; an element out of use issues
// no lanes. At a row end each result passes the accumulator and bias memory
// reads and then the result register. A stalled receiver holds the result
// register; the queue keeps accepting beats until it fills. Reset empties
// the queue, zeroes the accumulators and restores gradient mute off,
// in_used=16, out_used=16; weights and biases stay undefined until loaded.
module fully_connected_layer_engine import fc_pkg::*; #(
  parameter int MAX_IN  = 16,
  parameter int MAX_OUT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], value[23:8]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_index[3:0], out_value[19:4], zero[23:20]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int NI_MAX = (MAX_IN < LANES) ? MAX_IN : LANES;
  localparam int NO_MAX = (MAX_OUT < LANES) ? MAX_OUT : LANES;

  logic       first_q;
  logic [4:0] in_used_q, out_used_q;
  cfg_t       cfg;
  cmd_t       f_cmd, q_cmd;
  logic       q_full, q_valid, q_pop, push;

  // Hold the raw register values; clamp on the way out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b0;
      in_used_q  <= 5'd16;
      out_used_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRAD_MUTE: first_q    <= cfg_data_i[0];
        REG_IN_USED:   in_used_q  <= cfg_data_i;
        REG_OUT_USED:  out_used_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one; large counts cut to the smaller of the size parameter and the lane count.
  always_comb begin
    cfg.first = first_q;
    if (in_used_q == 5'd0) cfg.ni = 5'd1;
    else if (in_used_q > 5'(NI_MAX)) cfg.ni = 5'(NI_MAX);
    else cfg.ni = in_used_q;
    if (out_used_q == 5'd0) cfg.no = 5'd1;
    else if (out_used_q > 5'(NO_MAX)) cfg.no = 5'(NO_MAX);
    else cfg.no = out_used_q;
  end

  assign s_axis_tready = ~q_full;
  assign push          = s_axis_tvalid & ~q_full;

  fc_front #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_front (
    .func_i (s_axis_tuser),
    .data_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .cfg_i  (cfg),
    .cmd_o  (f_cmd)
  );

  fc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  fc_back #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the fully connected layer engine.
module tb_top;
  import fc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic [3:0]         idx;
    logic signed [15:0] value;
    logic               last;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  fully_connected_layer_engine uut (.*);

  // Predictor state, a mirror of the engine.
  logic signed [15:0] weights [16][16];
  logic signed [15:0] biases [16];
  logic [39:0]        acc [16];
  logic               first_q;
  logic [4:0]         in_q, out_q;

  elem_t       pending_beats[$];
  res_t        expected_results[$];
  int          send_idle_pct, recv_idle_pct;
  int          errors, beats_sent, results_seen, fwd_rows, bwd_rows;
  longint      cycle_count;

  function automatic int clamp_lanes(logic [4:0] n);
    if (n == 0) return 1;
    if (n > 16) return 16;
    return n;
  endfunction

  // Floor shift by 12, then saturate to 16 bits.
  function automatic logic signed [15:0] quantize(logic [39:0] s);
    logic signed [39:0] q;
    q = $signed(s) >>> 12;
    if (q > 40'sd32767) return 16'sh7fff;
    if (q < -40'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  task automatic predict_beat(elem_t e);
    int ni, no;
    logic signed [31:0] p;
    ni = clamp_lanes(in_q);
    no = clamp_lanes(out_q);
    case (e.func)
      FUNC_WLOAD: weights[e.row][e.col] = e.value;
      FUNC_BLOAD: biases[e.col] = e.value;
      default: begin
        if (e.func == FUNC_FWD && e.row < ni) begin
          for (int j = 0; j < no; j++) begin
            p = e.value * weights[e.row][j];
            acc[j] = acc[j] + {{8{p[31]}}, p};
          end
        end else if (e.func == FUNC_BWD && e.col < no) begin
          for (int j = 0; j < ni; j++) begin
            p = e.value * weights[j][e.col];
            acc[j] = acc[j] + {{8{p[31]}}, p};
          end
        end
        if (e.last) begin
          if (e.func == FUNC_FWD) begin
            for (int j = 0; j < no; j++)
              expected_results.push_back('{j[3:0],
                quantize(acc[j] + {{12{biases[j][15]}}, biases[j], 12'd0}), j == no - 1});
          end else if (!first_q) begin
            for (int j = 0; j < ni; j++)
              expected_results.push_back('{j[3:0], quantize(acc[j]), j == ni - 1});
          end
          foreach (acc[j]) acc[j] = '0;
        end
      end
    endcase
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Driver: present the head of the queue, pop it on each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(pending_beats.pop_front());
        beats_sent++;
      end
      if ((!s_axis_tvalid || s_axis_tready) || 1'b0) begin
        if (!(s_axis_tvalid && !s_axis_tready)) begin
          if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= pending_beats[0].func;
            s_axis_tdata  <= {pending_beats[0].value, pending_beats[0].col,
                              pending_beats[0].row};
            s_axis_tlast  <= pending_beats[0].last;
          end else begin
            s_axis_tvalid <= 1'b0;
          end
        end
      end
    end
  end

  // Monitor: compare each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat idx=%0d", m_axis_tdata[3:0]);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[3:0] !== exp_r.idx) begin
            $error("out_index exp %0d got %0d", exp_r.idx, m_axis_tdata[3:0]); errors++;
          end
          if ($signed(m_axis_tdata[19:4]) !== exp_r.value) begin
            $error("out_value exp %0d got %0d", exp_r.value, $signed(m_axis_tdata[19:4]));
            errors++;
          end
          if (m_axis_tdata[23:20] !== 4'd0) begin
            $error("pad exp 0 got %0h", m_axis_tdata[23:20]); errors++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("out_last exp %0b got %0b", exp_r.last, m_axis_tlast); errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (cycle_count > 3_000_000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Wait for the engine to drain, then write a register while idle.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRAD_MUTE: first_q = data[0];
      REG_IN_USED:   in_q = data;
      default:       out_q = data;
    endcase
  endtask

  function automatic logic [15:0] rnd_value();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(16'h1fff));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push(logic [1:0] f, int r, int c, logic [15:0] v, logic l);
    pending_beats.push_back('{f, r[3:0], c[3:0], v, l});
  endtask

  // Load the top-left 8x8 block, all of row 0 and column 0, and every bias;
  // rows and lane counts are kept so that only these entries are ever read.
  task automatic load_all();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        if ((r < 8 && c < 8) || r == 0 || c == 0)
          push(FUNC_WLOAD, r, c,
               (r == 0 || c == 0) ? (((r + c) % 2 != 0) ? 16'h7fff : 16'h8000)
                                  : rnd_value(),
               1'($urandom_range(1)));
    for (int c = 0; c < 16; c++) push(FUNC_BLOAD, 0, c, rnd_value(), 1'($urandom_range(1)));
  endtask

  // One row: a run of elements mostly in one mode, now and then one of the other, the last flagged.
  task automatic push_row(logic [1:0] f, int len);
    for (int k = 0; k < len; k++)
      push(($urandom_range(9) == 0) ? (f ^ 2'b01) : f, $urandom_range(15), $urandom_range(15),
           rnd_value(), k == len - 1);
    if (f == FUNC_FWD) fwd_rows++; else bwd_rows++;
  endtask

  task automatic random_phase(int n);
    int f;
    for (int i = 0; i < n;) begin
      f = $urandom_range(9);
      if (f == 0) begin
        push($urandom_range(1) ? FUNC_WLOAD : FUNC_BLOAD, $urandom_range(15),
             $urandom_range(15), rnd_value(), 1'($urandom_range(1)));
        i++;
      end else begin
        f = $urandom_range(3, 1);
        push_row(f[0] ? FUNC_FWD : FUNC_BWD, f);
        i += f;
      end
    end
  endtask

  initial begin
    send_idle_pct = 38; recv_idle_pct = 52;
    first_q = 1'b0; in_q = 5'd16; out_q = 5'd16;
    foreach (acc[j]) acc[j] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturating extremes at full size, both modes, mixed row.
    load_all();
    push(FUNC_FWD, 0, 0, 16'h7fff, 1'b0);
    push(FUNC_FWD, 0, 0, 16'h7fff, 1'b1);
    push(FUNC_BWD, 0, 0, 16'h8000, 1'b1);
    push(FUNC_FWD, 0, 0, 16'h7fff, 1'b0);
    push(FUNC_BWD, 0, 0, 16'h4000, 1'b1);
    push(FUNC_FWD, 0, 0, 16'h0000, 1'b1);
    write_reg(REG_IN_USED, 5'd3);
    write_reg(REG_OUT_USED, 5'd1);
    push(FUNC_FWD, 5, 0, 16'h1234, 1'b1);   // row out of use, last still fires
    push(FUNC_BWD, 0, 4, 16'h1234, 1'b1);   // column out of use
    push(FUNC_FWD, 2, 9, 16'hffff, 1'b1);
    write_reg(REG_GRAD_MUTE, 1'b1);
    push(FUNC_BWD, 0, 0, 16'h7fff, 1'b1);   // suppressed
    push(FUNC_FWD, 1, 0, 16'h0100, 1'b1);
    write_reg(REG_GRAD_MUTE, 1'b0);
    write_reg(REG_IN_USED, 5'd0);           // zero acts as one
    write_reg(REG_OUT_USED, 5'd31);         // above range clips to 16
    push(FUNC_BWD, 3, 3, 16'h8000, 1'b1);
    push(FUNC_FWD, 0, 3, 16'h7fff, 1'b1);

    // Random phases with varying sizes and idling profiles.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 52; recv_idle_pct = 38; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(REG_GRAD_MUTE, ph == 3);
      write_reg(REG_IN_USED, (ph == 5) ? 5'd8 : 5'($urandom_range(1, 5)));
      write_reg(REG_OUT_USED, (ph == 1) ? 5'd8 : 5'($urandom_range(1, 5)));
      random_phase(33);
    end

    wait_drained();
    $display("covered %0d beats, %0d results, %0d forward and %0d backward rows",
             beats_sent, results_seen, fwd_rows, bwd_rows);
    $display("gradient mute toggled, lane counts from zero up to 31 with clipping");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
